// ===== rtl/mhng_pkg.sv =====
// Shared types, constants and codes for the MIDI harmonic note generator.
// Used by every module of the block; depends on nothing else.
package mhng_pkg;

  // Default sizes of the block
  localparam int unsigned ActiveDepth   = 8;
  localparam int unsigned HarmonicCount = 8;
  localparam int unsigned QueueDepth    = 2;

  // Harmonics 2..8 map to level slots 0..6
  localparam int unsigned NumLevels = 7;
  localparam int unsigned LvlIdxW   = 3;
  localparam logic [LvlIdxW-1:0] LastLevel = 3'd6;

  // Semitone offset of each harmonic above its root, slot 0 first
  localparam logic [NumLevels-1:0][5:0] Semis =
    {6'd36, 6'd34, 6'd31, 6'd28, 6'd24, 6'd19, 6'd12};

  // Velocity scaling: floor(x / 100) = (x * VelRecip) >> VelShift for x < 43690
  localparam logic [12:0] VelRecip = 13'd5243;
  localparam int unsigned VelShift = 19;
  localparam logic [6:0]  VelMax   = 7'd127;
  localparam logic [6:0]  VelMin   = 7'd1;

  // MIDI codes
  localparam logic [3:0] StatusNoteOff = 4'h8;
  localparam logic [3:0] StatusNoteOn  = 4'h9;
  localparam logic [3:0] StatusControl = 4'hB;
  localparam logic [6:0] AllOffCc      = 7'd123;
  localparam logic [7:0] NoteMax       = 8'd127;

  // Configuration port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_LEVEL_2 = 3'd1,
    REG_LEVEL_3 = 3'd2,
    REG_LEVEL_4 = 3'd3,
    REG_LEVEL_5 = 3'd4,
    REG_LEVEL_6 = 3'd5,
    REG_LEVEL_7 = 3'd6,
    REG_LEVEL_8 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                        harmonic_enable;
    logic [NumLevels-1:0][6:0]   level;
  } cfg_t;

  // Channel payloads
  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [15:0] sample_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_status;
    logic [6:0]  out_first;
    logic [6:0]  out_second;
    logic [15:0] out_offset;
    logic        last_of_run;
    logic        table_overflow;
  } out_item_t;

  // Classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_PASS     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_ALL_OFF  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    in_item_t              evt;
    logic [NumLevels-1:0]  elig;
  } cmd_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_FIRST = 3'd1,
    ST_HMUL  = 3'd2,
    ST_HOUT  = 3'd3,
    ST_SCAN  = 3'd4,
    ST_REL   = 3'd5,
    ST_SHIFT = 3'd6
  } back_state_e;

endpackage

// ===== rtl/mhng_regs.sv =====
// APB-style configuration registers: harmonic enable and seven levels.
// Depends on mhng_pkg.
module mhng_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mhng_pkg::AddrW-1:0]  paddr,
  input  logic [mhng_pkg::DataW-1:0]  pwdata,
  output logic [mhng_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output mhng_pkg::cfg_t              cfg_o
);

  mhng_pkg::cfg_t     cfg_q, cfg_d;
  mhng_pkg::reg_idx_e idx;
  logic               wr_en;
  logic [mhng_pkg::LvlIdxW-1:0] lvl_idx;

  assign idx     = mhng_pkg::reg_idx_e'(paddr[4:2]);
  assign lvl_idx = mhng_pkg::LvlIdxW'(paddr[4:2] - 3'd1);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Decode a write into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (idx == mhng_pkg::REG_ENABLE) begin
        cfg_d.harmonic_enable = pwdata[0];
      end else begin
        cfg_d.level[lvl_idx] = pwdata[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register
  always_comb begin
    if (idx == mhng_pkg::REG_ENABLE) begin
      prdata = mhng_pkg::DataW'(cfg_q.harmonic_enable);
    end else begin
      prdata = mhng_pkg::DataW'(cfg_q.level[lvl_idx]);
    end
  end

endmodule

// ===== rtl/mhng_front.sv =====
// Front end: accepts input events, classifies them and picks eligible harmonics.
// Depends on mhng_pkg; feeds mhng_queue.
module mhng_front #(
  parameter int unsigned HarmonicCount = mhng_pkg::HarmonicCount
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mhng_pkg::in_item_t in_data_i,
  input  mhng_pkg::cfg_t     cfg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output mhng_pkg::cmd_t     q_data_o
);

  logic [3:0]                     kind_nib;
  logic [7:0]                     note_sum [mhng_pkg::NumLevels];
  mhng_pkg::cmd_kind_e            cmd_kind;
  logic [mhng_pkg::NumLevels-1:0] elig;

  assign kind_nib   = in_data_i.status_byte[7:4];
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the event
  always_comb begin
    cmd_kind = mhng_pkg::CMD_PASS;
    if (cfg_i.harmonic_enable) begin
      if (kind_nib == mhng_pkg::StatusNoteOn && in_data_i.second_data != 7'd0) begin
        cmd_kind = mhng_pkg::CMD_NOTE_ON;
      end else if (kind_nib inside {mhng_pkg::StatusNoteOff, mhng_pkg::StatusNoteOn}) begin
        cmd_kind = mhng_pkg::CMD_NOTE_OFF;
      end else if (kind_nib == mhng_pkg::StatusControl &&
                   in_data_i.first_data == mhng_pkg::AllOffCc) begin
        cmd_kind = mhng_pkg::CMD_ALL_OFF;
      end
    end
  end

  // Mark harmonics with a usable level whose shifted note stays in range
  always_comb begin
    for (int h = 0; h < mhng_pkg::NumLevels; h++) begin
      note_sum[h] = 8'(in_data_i.first_data) + 8'(mhng_pkg::Semis[h]);
      elig[h] = (cmd_kind == mhng_pkg::CMD_NOTE_ON) &&
                (h < int'(HarmonicCount) - 1) &&
                (cfg_i.level[h] > 7'd1) &&
                (note_sum[h] <= mhng_pkg::NoteMax);
    end
  end

  // Assemble the command for the queue
  always_comb begin
    q_data_o.kind = cmd_kind;
    q_data_o.evt  = in_data_i;
    q_data_o.elig = elig;
  end

endmodule

// ===== rtl/mhng_queue.sv =====
// Short command queue between the front and back ends.
// Depends on mhng_pkg for the command type.
module mhng_queue #(
  parameter int unsigned Depth = mhng_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mhng_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mhng_pkg::cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mhng_pkg::cmd_t    mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Store an entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mhng_back.sv =====
// Back end: sequences the results of one command, keeps the active-note table
// and holds the output register. Depends on mhng_pkg.
module mhng_back #(
  parameter int unsigned ActiveDepth = mhng_pkg::ActiveDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhng_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  mhng_pkg::cmd_t      q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mhng_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW = (ActiveDepth > 1) ? $clog2(ActiveDepth) : 1;
  localparam int unsigned CntW = $clog2(ActiveDepth + 1);
  localparam int unsigned L    = mhng_pkg::NumLevels;

  mhng_pkg::back_state_e state_q, state_d;

  // Command in progress
  mhng_pkg::cmd_t          cmd_q;
  logic [ActiveDepth-1:0]  hit_q, hitnz_q, hit_d, hitnz_d;
  logic                    ovf_q;
  logic [mhng_pkg::LvlIdxW-1:0] h_q;
  logic [IdxW-1:0]         idx_q;
  logic [6:0]              cur_root_q;
  logic [L-1:0]            cur_mask_q;
  logic [13:0]             prod_q;

  // Active-note table, oldest entry at index 0
  logic [6:0]              slot_root_q [ActiveDepth];
  logic [L-1:0]            slot_mask_q [ActiveDepth];
  logic [CntW-1:0]         count_q;

  // Output register
  logic                    out_valid_q;
  mhng_pkg::out_item_t     out_q;

  logic                    emit_req, out_free, step, h_last, table_full;
  mhng_pkg::out_item_t     res;
  logic [3:0]              chan;
  logic [26:0]             scaled;
  logic [7:0]              vel_raw;
  logic [6:0]              vel;
  logic [7:0]              harm_note;
  logic [L-1:0]            above_h;
  logic [ActiveDepth-1:0]  below_idx;

  assign chan        = cmd_q.evt.status_byte[3:0];
  assign out_free    = !out_valid_q || out_ready_i;
  assign step        = !emit_req || out_free;
  assign h_last      = (h_q == mhng_pkg::LastLevel);
  assign table_full  = (count_q >= CntW'(ActiveDepth));
  assign above_h     = ~((L'(2) << h_q) - L'(1));
  assign below_idx   = (ActiveDepth'(1) << idx_q) - ActiveDepth'(1);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Scale velocity by level / 100 and clamp to 1..127
  assign scaled    = 27'(prod_q) * 27'(mhng_pkg::VelRecip);
  assign vel_raw   = scaled[26:mhng_pkg::VelShift];
  assign harm_note = 8'(cmd_q.evt.first_data) + 8'(mhng_pkg::Semis[h_q]);
  always_comb begin
    if (vel_raw == 8'd0) begin
      vel = mhng_pkg::VelMin;
    end else if (vel_raw > 8'(mhng_pkg::VelMax)) begin
      vel = mhng_pkg::VelMax;
    end else begin
      vel = vel_raw[6:0];
    end
  end

  // Match the table against a note-off root at the queue head
  always_comb begin
    for (int i = 0; i < ActiveDepth; i++) begin
      hit_d[i]   = (q_data_i.kind == mhng_pkg::CMD_NOTE_OFF) &&
                   (CntW'(i) < count_q) &&
                   (slot_root_q[i] == q_data_i.evt.first_data);
      hitnz_d[i] = hit_d[i] && (slot_mask_q[i] != '0);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mhng_pkg::ST_IDLE: begin
        if (q_valid_i) state_d = mhng_pkg::ST_FIRST;
      end
      mhng_pkg::ST_FIRST: begin
        if (step) begin
          if (cmd_q.elig != '0)      state_d = mhng_pkg::ST_HMUL;
          else if (hit_q != '0)      state_d = mhng_pkg::ST_SCAN;
          else                       state_d = mhng_pkg::ST_IDLE;
        end
      end
      mhng_pkg::ST_HMUL: state_d = mhng_pkg::ST_HOUT;
      mhng_pkg::ST_HOUT: begin
        if (step) state_d = h_last ? mhng_pkg::ST_IDLE : mhng_pkg::ST_HMUL;
      end
      mhng_pkg::ST_SCAN: begin
        if (hit_q[idx_q])         state_d = mhng_pkg::ST_REL;
        else if (idx_q == '0)     state_d = mhng_pkg::ST_IDLE;
      end
      mhng_pkg::ST_REL: begin
        if (step && h_last) state_d = mhng_pkg::ST_SHIFT;
      end
      mhng_pkg::ST_SHIFT: begin
        state_d = (idx_q == '0) ? mhng_pkg::ST_IDLE : mhng_pkg::ST_SCAN;
      end
      default: state_d = mhng_pkg::ST_IDLE;
    endcase
  end

  // Outputs of each state
  always_comb begin
    q_pop_o  = 1'b0;
    emit_req = 1'b0;
    res      = '0;
    res.out_offset     = cmd_q.evt.sample_offset;
    res.table_overflow = ovf_q;
    case (state_q)
      mhng_pkg::ST_IDLE: q_pop_o = q_valid_i;
      mhng_pkg::ST_FIRST: begin
        emit_req        = 1'b1;
        res.out_status  = cmd_q.evt.status_byte;
        res.out_first   = cmd_q.evt.first_data;
        res.out_second  = cmd_q.evt.second_data;
        res.last_of_run = (cmd_q.elig == '0) && (hitnz_q == '0);
      end
      mhng_pkg::ST_HOUT: begin
        emit_req        = cmd_q.elig[h_q];
        res.out_status  = {mhng_pkg::StatusNoteOn, chan};
        res.out_first   = harm_note[6:0];
        res.out_second  = vel;
        res.last_of_run = (cmd_q.elig & above_h) == '0;
      end
      mhng_pkg::ST_REL: begin
        emit_req        = cur_mask_q[h_q];
        res.out_status  = {mhng_pkg::StatusNoteOff, chan};
        res.out_first   = 7'(8'(cur_root_q) + 8'(mhng_pkg::Semis[h_q]));
        res.out_second  = '0;
        res.last_of_run = ((cur_mask_q & above_h) == '0) &&
                          ((hitnz_q & below_idx) == '0);
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhng_pkg::ST_IDLE;
      hit_q   <= '0;
      hitnz_q <= '0;
      ovf_q   <= 1'b0;
      h_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        mhng_pkg::ST_IDLE: begin
          if (q_valid_i) begin
            hit_q   <= hit_d;
            hitnz_q <= hitnz_d;
            ovf_q   <= (q_data_i.kind == mhng_pkg::CMD_NOTE_ON) && table_full;
          end
        end
        mhng_pkg::ST_FIRST: begin
          h_q   <= '0;
          idx_q <= IdxW'(ActiveDepth - 1);
        end
        mhng_pkg::ST_HOUT, mhng_pkg::ST_REL: begin
          if (step && !h_last) h_q <= h_q + 1'b1;
        end
        mhng_pkg::ST_SCAN: begin
          h_q <= '0;
          if (!hit_q[idx_q] && idx_q != '0) idx_q <= idx_q - 1'b1;
        end
        mhng_pkg::ST_SHIFT: begin
          if (idx_q != '0) idx_q <= idx_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Command payload, product and current release entry
  always_ff @(posedge clk_i) begin
    if (state_q == mhng_pkg::ST_IDLE && q_valid_i) begin
      cmd_q <= q_data_i;
    end
    if (state_q == mhng_pkg::ST_HMUL) begin
      prod_q <= 14'(cmd_q.evt.second_data) * 14'(cfg_i.level[h_q]);
    end
    if (state_q == mhng_pkg::ST_SCAN) begin
      cur_root_q <= slot_root_q[idx_q];
      cur_mask_q <= slot_mask_q[idx_q];
    end
  end

  // Table fill count: push, remove, clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (state_q == mhng_pkg::ST_IDLE && q_valid_i) begin
      if (q_data_i.kind == mhng_pkg::CMD_ALL_OFF) begin
        count_q <= '0;
      end else if (q_data_i.kind == mhng_pkg::CMD_NOTE_ON && !table_full) begin
        count_q <= count_q + 1'b1;
      end
    end else if (state_q == mhng_pkg::ST_SHIFT) begin
      count_q <= count_q - 1'b1;
    end
  end

  // Table entries: append a note-on, close the gap of a released entry
  always_ff @(posedge clk_i) begin
    if (state_q == mhng_pkg::ST_IDLE && q_valid_i &&
        q_data_i.kind == mhng_pkg::CMD_NOTE_ON && !table_full) begin
      slot_root_q[count_q[IdxW-1:0]] <= q_data_i.evt.first_data;
      slot_mask_q[count_q[IdxW-1:0]] <= q_data_i.elig;
    end else if (state_q == mhng_pkg::ST_SHIFT) begin
      for (int j = 0; j < int'(ActiveDepth) - 1; j++) begin
        if (IdxW'(j) >= idx_q) begin
          slot_root_q[j] <= slot_root_q[j+1];
          slot_mask_q[j] <= slot_mask_q[j+1];
        end
      end
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_req && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_req && out_free) begin
      out_q <= res;
    end
  end

endmodule

// ===== rtl/midi_harmonic_note_generator.sv =====
// MIDI harmonic note generator: front classifier, command queue, back sequencer
// with active-note table and APB-style registers. Depends on mhng_pkg.
//
// Every input event comes back first unchanged; with harmonics enabled a
// note-on adds up to seven harmonic note-ons and is recorded in an
// ActiveDepth-entry table, and a note-off releases every recorded entry of
// that root, newest first, with velocity-0 note-offs. Results leave one per
// cycle at most. In the back sequencer, a note-on with at least one harmonic
// takes a multiply and an output step per harmonic slot, and a note-off that
// matches scans the table and, for each released entry, steps through the
// seven harmonic slots and then shifts the table. The two-entry command queue
// takes further events while the back is busy. The table starts empty after
// reset; no clearing pass is needed.
module midi_harmonic_note_generator #(
  parameter int unsigned ActiveDepth   = mhng_pkg::ActiveDepth,
  parameter int unsigned HarmonicCount = mhng_pkg::HarmonicCount
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mhng_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mhng_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mhng_pkg::AddrW-1:0]  paddr,
  input  logic [mhng_pkg::DataW-1:0]  pwdata,
  output logic [mhng_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  mhng_pkg::cfg_t cfg;
  mhng_pkg::cmd_t push_cmd, head_cmd;
  logic           q_full, q_push, q_valid, q_pop;

  mhng_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mhng_front #(
    .HarmonicCount (HarmonicCount)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (push_cmd)
  );

  mhng_queue #(
    .Depth (mhng_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (head_cmd)
  );

  mhng_back #(
    .ActiveDepth (ActiveDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for midi_harmonic_note_generator: drives MIDI events and
// APB register writes, predicts every result beat and compares it on arrival.
// Depends on rtl/mhng_pkg.sv and rtl/midi_harmonic_note_generator.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // MIDI codes and table size as the block sees them
  localparam logic [3:0] MidiNoteOff = mhng_pkg::StatusNoteOff;
  localparam logic [3:0] MidiNoteOn  = mhng_pkg::StatusNoteOn;
  localparam logic [3:0] MidiControl = mhng_pkg::StatusControl;
  localparam logic [6:0] CcAllOff    = mhng_pkg::AllOffCc;
  localparam logic [7:0] TopNote     = 8'd127;
  localparam int         NumHarm     = 7;
  localparam int         TableDepth  = 8;

  // Semitone offset of harmonics 2..8, harmonic 2 in slot 0
  localparam logic [NumHarm-1:0][6:0] HarmSemis =
    {7'd36, 7'd34, 7'd31, 7'd28, 7'd24, 7'd19, 7'd12};

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  mhng_pkg::in_item_t             in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  mhng_pkg::out_item_t            out_data_o;
  logic                           psel        = 1'b0;
  logic                           penable     = 1'b0;
  logic                           pwrite      = 1'b0;
  logic [mhng_pkg::AddrW-1:0]     paddr       = '0;
  logic [mhng_pkg::DataW-1:0]     pwdata      = '0;
  logic [mhng_pkg::DataW-1:0]     prdata;
  logic                           pready;

  midi_harmonic_note_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the registers and the active-note table
  logic                 harm_en = 1'b0;
  logic [6:0]           level_pct [NumHarm];
  logic [6:0]           note_root [TableDepth];
  logic [6:0]           note_mask [TableDepth];
  int                   note_count = 0;
  mhng_pkg::out_item_t  pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int mismatch_count = 0;
  int beats_checked  = 0;
  int overflow_beats = 0;
  int events_sent    = 0;

  // Work out every result beat of one accepted event, update the table shadow
  function automatic void predict_event(input mhng_pkg::in_item_t ev);
    mhng_pkg::out_item_t  run [$];
    mhng_pkg::out_item_t  r;
    logic [3:0] kind;
    logic [3:0] chan;
    logic [7:0] shifted;
    logic [6:0] mask;
    logic       ovf;
    int         vel;
    kind = ev.status_byte[7:4];
    chan = ev.status_byte[3:0];
    mask = '0;
    ovf  = 1'b0;
    r.out_status     = ev.status_byte;
    r.out_first      = ev.first_data;
    r.out_second     = ev.second_data;
    r.out_offset     = ev.sample_offset;
    r.last_of_run    = 1'b0;
    r.table_overflow = 1'b0;
    run.push_back(r);
    if (harm_en) begin
      if (kind == MidiNoteOn && ev.second_data != 7'd0) begin
        // add harmonics whose level is above 1 and whose note stays in range
        for (int h = 0; h < NumHarm; h++) begin
          shifted = {1'b0, ev.first_data} + {1'b0, HarmSemis[h]};
          if (level_pct[h] > 7'd1 && shifted <= TopNote) begin
            vel = (int'(ev.second_data) * int'(level_pct[h])) / 100;
            if (vel < 1) vel = 1;
            if (vel > 127) vel = 127;
            r.out_status = {MidiNoteOn, chan};
            r.out_first  = shifted[6:0];
            r.out_second = vel[6:0];
            run.push_back(r);
            mask[h] = 1'b1;
          end
        end
        // track the note, or flag the overflow when the table is full
        if (note_count < TableDepth) begin
          note_root[note_count] = ev.first_data;
          note_mask[note_count] = mask;
          note_count++;
        end else begin
          ovf = 1'b1;
        end
      end else if (kind == MidiNoteOff || kind == MidiNoteOn) begin
        // release matching entries, newest first
        for (int i = note_count - 1; i >= 0; i--) begin
          if (note_root[i] == ev.first_data) begin
            for (int h = 0; h < NumHarm; h++) begin
              if (note_mask[i][h]) begin
                r.out_status = {MidiNoteOff, chan};
                r.out_first  = note_root[i] + HarmSemis[h];
                r.out_second = 7'd0;
                run.push_back(r);
              end
            end
            for (int j = i; j + 1 < note_count; j++) begin
              note_root[j] = note_root[j + 1];
              note_mask[j] = note_mask[j + 1];
            end
            note_count--;
          end
        end
      end else if (kind == MidiControl && ev.first_data == CcAllOff) begin
        note_count = 0;
      end
    end
    run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[k]) begin
      run[k].table_overflow = ovf;
      pending_results.push_back(run[k]);
    end
  endfunction

  function automatic mhng_pkg::in_item_t midi_event(input logic [7:0] st,
                                                    input logic [6:0] d1,
                                                    input logic [6:0] d2,
                                                    input logic [15:0] t);
    mhng_pkg::in_item_t ev;
    ev.status_byte   = st;
    ev.first_data    = d1;
    ev.second_data   = d2;
    ev.sample_offset = t;
    return ev;
  endfunction

  // Offer one event, keep valid high into the next call unless the sender idles
  task automatic send_event(input mhng_pkg::in_item_t ev);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    predict_event(ev);
    events_sent++;
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, then the bus idles before the task returns
  task automatic write_reg(input mhng_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == mhng_pkg::REG_ENABLE) harm_en = value[0];
    else level_pct[int'(idx) - int'(mhng_pkg::REG_LEVEL_2)] = value[6:0];
    @(posedge clk_i);
  endtask

  // Drain the block, then write every register; lv[0] is the second harmonic
  task automatic apply_config(input logic en, input logic [NumHarm-1:0][6:0] lv);
    wait_drain();
    write_reg(mhng_pkg::REG_ENABLE, {31'd0, en});
    for (int h = 0; h < NumHarm; h++) begin
      write_reg(mhng_pkg::reg_idx_e'(int'(mhng_pkg::REG_LEVEL_2) + h), {25'd0, lv[h]});
    end
  endtask

  // Reset values: harmonics off, events pass straight through
  task automatic test_reset_passthrough();
    send_event(midi_event({MidiNoteOn, 4'h3}, 7'd60, 7'd100, 16'h1234));
    end_burst();
  endtask

  // Harmonics at full level, table tracking, overflow, clear and pass-through kinds
  task automatic test_note_tracking();
    apply_config(1'b1, {NumHarm{7'd100}});
    send_event(midi_event({MidiNoteOn, 4'h0}, 7'd0, 7'd127, 16'h0000));
    send_event(midi_event({MidiNoteOn, 4'hF}, 7'd100, 7'd1, 16'hFFFF));
    send_event(midi_event({MidiNoteOn, 4'h0}, 7'd0, 7'd64, 16'h0101));
    // note with no harmonic in range is tracked with an empty mask
    send_event(midi_event({MidiNoteOn, 4'hF}, 7'd127, 7'd127, 16'h0202));
    // two entries share root 0: both go, newest first
    send_event(midi_event({MidiNoteOff, 4'h0}, 7'd0, 7'd64, 16'h0303));
    // note-on with zero velocity acts as note-off
    send_event(midi_event({MidiNoteOn, 4'hF}, 7'd100, 7'd0, 16'h0404));
    send_event(midi_event({MidiNoteOff, 4'hF}, 7'd127, 7'd0, 16'h0505));
    // fill the table, the ninth note overflows
    for (int n = 0; n <= TableDepth; n++) begin
      send_event(midi_event({MidiNoteOn, 4'h5}, 7'(10 + n), 7'd127, 16'(n)));
    end
    send_event(midi_event({MidiControl, 4'h5}, CcAllOff, 7'd0, 16'h0606));
    send_event(midi_event({MidiNoteOff, 4'h5}, 7'd10, 7'd0, 16'h0707));
    send_event(midi_event({MidiControl, 4'h2}, 7'd7, 7'd100, 16'h0808));
    send_event(midi_event(8'hF0, 7'd127, 7'd127, 16'hFFFF));
    send_event(midi_event(8'h00, 7'd5, 7'd5, 16'h0909));
    end_burst();
  endtask

  // Levels of 0, 1, small, half and above 100; velocity clamps at both ends
  task automatic test_level_edges();
    apply_config(1'b1, {7'd100, 7'd3, 7'd127, 7'd50, 7'd2, 7'd1, 7'd0});
    send_event(midi_event({MidiNoteOn, 4'h1}, 7'd5, 7'd127, 16'h0A0A));
    send_event(midi_event({MidiNoteOn, 4'h1}, 7'd6, 7'd1, 16'h0B0B));
    end_burst();
  endtask

  // Disabled: note events pass through and leave the table alone
  task automatic test_disabled();
    apply_config(1'b0, {7'd100, 7'd3, 7'd127, 7'd50, 7'd2, 7'd1, 7'd0});
    send_event(midi_event({MidiNoteOn, 4'h1}, 7'd40, 7'd90, 16'h0C0C));
    send_event(midi_event({MidiNoteOff, 4'h1}, 7'd5, 7'd0, 16'h0D0D));
    end_burst();
  endtask

  // Hold the receiver off while notes pile up, then pause until all beats are out
  task automatic test_backpressure();
    apply_config(1'b1, {NumHarm{7'd100}});
    send_idle_pct = 0;
    recv_idle_pct = 20;
    hold_request  = 300;
    for (int n = 0; n < 12; n++) begin
      send_event(midi_event({MidiNoteOn, 4'h7}, 7'(20 + n), 7'($urandom_range(127, 1)),
                            16'($urandom_range(65535))));
    end
    end_burst();
    wait_drain();
    for (int n = 0; n < TableDepth; n++) begin
      send_event(midi_event({MidiNoteOff, 4'h7}, 7'(20 + n), 7'd0,
                            16'($urandom_range(65535))));
    end
    send_event(midi_event({MidiControl, 4'h7}, CcAllOff, 7'd0, 16'h0E0E));
    end_burst();
  endtask

  // Mostly note-on/note-off traffic on a few roots, some all-off and raw noise
  task automatic test_random_traffic(input int n_events, input int snd_pct, input int rcv_pct);
    logic [6:0]               pool [5];
    logic [NumHarm-1:0][6:0]  lv;
    logic [3:0]               chan;
    logic [6:0]               note;
    int                       pick;
    mhng_pkg::in_item_t       ev;
    for (int i = 0; i < 5; i++) pool[i] = 7'($urandom_range(127));
    for (int h = 0; h < NumHarm; h++) begin
      case ($urandom_range(5))
        0: lv[h] = 7'd0;
        1: lv[h] = 7'd1;
        2: lv[h] = 7'd2;
        3: lv[h] = 7'd100;
        4: lv[h] = 7'd127;
        default: lv[h] = 7'($urandom_range(127));
      endcase
    end
    apply_config($urandom_range(9) != 0, lv);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int i = 0; i < n_events; i++) begin
      pick = $urandom_range(99);
      chan = 4'($urandom_range(15));
      ev.sample_offset = 16'($urandom_range(65535));
      if (pick < 45) begin
        note = ($urandom_range(9) < 7) ? pool[$urandom_range(4)] : 7'($urandom_range(127));
        ev.status_byte = {MidiNoteOn, chan};
        ev.first_data  = note;
        ev.second_data = 7'($urandom_range(127, 1));
      end else if (pick < 80) begin
        note = ($urandom_range(9) < 8) ? pool[$urandom_range(4)] : 7'($urandom_range(127));
        ev.first_data = note;
        if ($urandom_range(1) == 0) begin
          ev.status_byte = {MidiNoteOff, chan};
          ev.second_data = 7'($urandom_range(127));
        end else begin
          ev.status_byte = {MidiNoteOn, chan};
          ev.second_data = 7'd0;
        end
      end else if (pick < 85) begin
        ev.status_byte = {MidiControl, chan};
        ev.first_data  = CcAllOff;
        ev.second_data = 7'($urandom_range(127));
      end else begin
        ev.status_byte = 8'($urandom_range(255));
        ev.first_data  = 7'($urandom_range(127));
        ev.second_data = 7'($urandom_range(127));
      end
      send_event(ev);
    end
    end_burst();
  endtask

  // Receiver: random ready, or a counted hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    mhng_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_checked++;
      if (out_data_o.table_overflow) overflow_beats++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no beat, got st=%h n=%0d v=%0d t=%h last=%b ovf=%b",
                 $time, out_data_o.out_status, out_data_o.out_first,
                 out_data_o.out_second, out_data_o.out_offset,
                 out_data_o.last_of_run, out_data_o.table_overflow);
      end else begin
        want = pending_results.pop_front();
        if (want.out_status !== out_data_o.out_status ||
            want.out_first !== out_data_o.out_first ||
            want.out_second !== out_data_o.out_second ||
            want.out_offset !== out_data_o.out_offset ||
            want.last_of_run !== out_data_o.last_of_run ||
            want.table_overflow !== out_data_o.table_overflow) begin
          mismatch_count++;
          $display("%0t: expected st=%h n=%0d v=%0d t=%h last=%b ovf=%b,",
                   $time, want.out_status, want.out_first, want.out_second,
                   want.out_offset, want.last_of_run, want.table_overflow);
          $display("    got st=%h n=%0d v=%0d t=%h last=%b ovf=%b",
                   out_data_o.out_status, out_data_o.out_first, out_data_o.out_second,
                   out_data_o.out_offset, out_data_o.last_of_run,
                   out_data_o.table_overflow);
        end
      end
    end
  end

  // Test sequence
  initial begin
    for (int h = 0; h < NumHarm; h++) level_pct[h] = 7'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 38;
    recv_idle_pct = 68;
    test_reset_passthrough();
    test_note_tracking();
    test_level_edges();
    test_disabled();
    test_random_traffic(110, 38, 68);
    test_random_traffic(110, 68, 38);
    test_random_traffic(110, 0, 0);
    test_backpressure();
    wait_drain();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d events: harmonics, level edges, releases, table overflow,",
             events_sent);
    $display("all-notes-off, pass-through and back-pressure; %0d beats checked,",
             beats_checked);
    $display("%0d of them with overflow.", overflow_beats);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mhng_pkg.sv
rtl/mhng_regs.sv
rtl/mhng_front.sv
rtl/mhng_queue.sv
rtl/mhng_back.sv
rtl/midi_harmonic_note_generator.sv
sim/tb.sv
